// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the seven-segment text raster.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is asserted.
`define SSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SSR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSR_ASSERT(label, clk, rst_n, prop, msg)
`define SSR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/ssr_pkg.sv =====
// Package for the seven-segment text raster: character codes, segment
// decode table and the glyph position struct. No dependencies.
package ssr_pkg;

    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;
    localparam int SCALE_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_BAR     = 7'd124;

    // Segment bits: a top, b upper right, c lower right, d bottom,
    // e lower left, f upper left, g middle.
    localparam int SEG_A = 0;
    localparam int SEG_B = 1;
    localparam int SEG_C = 2;
    localparam int SEG_D = 3;
    localparam int SEG_E = 4;
    localparam int SEG_F = 5;
    localparam int SEG_G = 6;

    // Where the current character sits inside a digit cell.
    typedef struct packed {
        logic row_top;
        logic row_mid;
        logic row_bot;
        logic upper_half;
        logic col_left;
        logic col_right;
        logic col_inner;
    } glyph_pos_t;

    // Segment mask for one digit; codes above nine draw a blank cell.
    function automatic logic [6:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [6:0] m;
        case (d)
            4'd0:    m = 7'b0111111;
            4'd1:    m = 7'b0000110;
            4'd2:    m = 7'b1011011;
            4'd3:    m = 7'b1001111;
            4'd4:    m = 7'b1100110;
            4'd5:    m = 7'b1101101;
            4'd6:    m = 7'b1111101;
            4'd7:    m = 7'b0000111;
            4'd8:    m = 7'b1111111;
            4'd9:    m = 7'b1101111;
            default: m = 7'b0000000;
        endcase
        return m;
    endfunction

endpackage

// ===== src/ssr_digit_store.sv =====
// Digit memory of the seven-segment text raster: one write port and one
// registered read port with write-first bypass. Uses nothing from ssr_pkg.
module ssr_digit_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A digit written in the same cycle as its read is forwarded.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ssr_cell_char.sv =====
// Glyph decode of the seven-segment text raster: picks the character for
// one position of a digit cell. Depends on ssr_pkg.
module ssr_cell_char (
    input  logic [ssr_pkg::DIGIT_W-1:0] digit,
    input  ssr_pkg::glyph_pos_t          pos,
    output logic [ssr_pkg::CHAR_W-1:0]  char_code
);

    logic [6:0] seg;
    logic       hbit;
    logic       lbit;
    logic       rbit;

    assign seg  = ssr_pkg::seg_decode(digit);
    assign hbit = pos.row_top ? seg[ssr_pkg::SEG_A] :
                  pos.row_mid ? seg[ssr_pkg::SEG_G] : seg[ssr_pkg::SEG_D];
    assign lbit = pos.upper_half ? seg[ssr_pkg::SEG_F] : seg[ssr_pkg::SEG_E];
    assign rbit = pos.upper_half ? seg[ssr_pkg::SEG_B] : seg[ssr_pkg::SEG_C];

    always_comb begin
        char_code = ssr_pkg::CHAR_SPACE;
        if (pos.row_top || pos.row_mid || pos.row_bot) begin
            if (pos.col_inner && hbit) begin
                char_code = ssr_pkg::CHAR_DASH;
            end
        end else if (pos.col_left) begin
            if (lbit) begin
                char_code = ssr_pkg::CHAR_BAR;
            end
        end else if (pos.col_right) begin
            if (rbit) begin
                char_code = ssr_pkg::CHAR_BAR;
            end
        end
    end

endmodule

// ===== src/scaled_seven_segment_text_raster_unit.sv =====
// Top level of the seven-segment text raster: handshakes, raster counters,
// configuration register. Depends on ssr_pkg, ssr_digit_store, ssr_cell_char.
//
//  Channel  | Ports                         | Beat carries
//  ---------+-------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata ... | digit (tdata), last digit (tlast),
//           |                               | load or tick (tuser)
//  result   | m_tvalid m_tready m_tdata ... | character (tdata), end of line
//           |                               | (tuser), end of frame (tlast)
//  config   | psel penable pwrite paddr ... | segment length at address 0
//
// One input beat is accepted per clock cycle while s_tready is high. A beat is
// captured in the input register and resolved against the raster counters once
// the result register can take it; its character is then held there for m_tdata.
// Reset is synchronous on aresetn low and clears the counters, the digit count
// and the scale (back to 2); the stored digits are not cleared.
// A stall on m_tready holds the result register and, through it, the input
// register; s_tready falls only when both are full and the result is not taken.
module scaled_seven_segment_text_raster_unit #(
    parameter int MAX_DIGITS = 16,
    parameter int MAX_SCALE  = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] kind: 0 load, 1 tick

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast,
    output logic        m_tuser,   // [0] end_of_line

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    // Widths that follow from the parameters.
    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int SW     = $clog2(MAX_SCALE + 1);
    localparam int ROW_W  = $clog2(2 * MAX_SCALE + 3);
    localparam int COL_W  = $clog2(MAX_SCALE + 3);

    localparam int DW = ssr_pkg::DIGIT_W;
    localparam int CW = ssr_pkg::CHAR_W;

    // Input register.
    logic          in_valid_reg, in_valid_next;
    logic          in_kind_reg;
    logic [DW-1:0] in_digit_reg;
    logic          in_last_reg;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_char_reg, out_char_next;
    logic          out_eol_reg, out_eol_next;
    logic          out_eof_reg, out_eof_next;

    // Block state.
    logic [ssr_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        open_reg, open_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ADDR_W-1:0]           cell_reg, cell_next;
    logic [COL_W-1:0]            col_reg, col_next;

    logic                        cfg_wr;
    logic                        advance;
    logic                        do_tick;
    logic                        do_load;

    logic [SW-1:0]               s_eff;
    logic [ROW_W-1:0]            s_row;
    logic [ROW_W-1:0]            mid_row;
    logic [ROW_W-1:0]            last_row;
    logic [COL_W-1:0]            s_col;
    logic [COL_W-1:0]            right_col;
    logic [COL_W-1:0]            gap_col;
    logic                        newline;
    logic                        at_gap;

    logic [CNT_W-1:0]            load_base;
    logic                        wr_en;
    logic [DW-1:0]               rd_digit;

    ssr_pkg::glyph_pos_t         gpos;
    logic [CW-1:0]               glyph_char;

    // Configuration port: one register, the segment length, at address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - ssr_pkg::SCALE_W){1'b0}}, scale_reg}
                                       : 32'd0;
    assign scale_next = cfg_wr ? pwdata[ssr_pkg::SCALE_W-1:0] : scale_reg;

    // Handshakes: the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign do_tick  = advance && in_kind_reg;
    assign do_load  = advance && !in_kind_reg;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    // Effective segment length: zero acts as one, too large acts as the max.
    always_comb begin
        if (scale_reg == '0) begin
            s_eff = SW'(1);
        end else if (scale_reg > ssr_pkg::SCALE_W'(MAX_SCALE)) begin
            s_eff = SW'(MAX_SCALE);
        end else begin
            s_eff = SW'(scale_reg);
        end
    end

    assign s_row     = ROW_W'(s_eff);
    assign mid_row   = s_row + ROW_W'(1);
    assign last_row  = (s_row << 1) + ROW_W'(2);
    assign s_col     = COL_W'(s_eff);
    assign right_col = s_col + COL_W'(1);
    assign gap_col   = s_col + COL_W'(2);

    // A row ends at the gap column of the last cell, where a newline takes the
    // place of the space, or at once when no digits are held.
    assign newline = (count_reg == '0) ||
                     ((CNT_W'(cell_reg) + CNT_W'(1) == count_reg) && (col_reg == gap_col));
    assign at_gap  = (col_reg == gap_col);

    // A load that opens a new number starts over at entry zero; loads past
    // the capacity are dropped but still close or keep the number open.
    assign load_base = open_reg ? count_reg : '0;
    assign wr_en     = do_load && (load_base < CNT_W'(MAX_DIGITS));

    // Raster position classes for the glyph decode.
    assign gpos.row_top    = (row_reg == '0);
    assign gpos.row_mid    = (row_reg == mid_row);
    assign gpos.row_bot    = (row_reg == last_row);
    assign gpos.upper_half = (row_reg < mid_row);
    assign gpos.col_left   = (col_reg == '0);
    assign gpos.col_right  = (col_reg == right_col);
    assign gpos.col_inner  = (col_reg != '0) && (col_reg <= s_col);

    ssr_cell_char u_cell_char (
        .digit     (rd_digit),
        .pos       (gpos),
        .char_code (glyph_char)
    );

    // The digit memory is read at the next cell position, so its registered
    // output always holds the digit of the current cell.
    ssr_digit_store #(
        .DEPTH  (MAX_DIGITS),
        .ADDR_W (ADDR_W),
        .DATA_W (DW)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (load_base[ADDR_W-1:0]),
        .wr_data (in_digit_reg),
        .rd_addr (cell_next),
        .rd_data (rd_digit)
    );

    // Next state of the counters and the result register.
    always_comb begin
        count_next     = count_reg;
        open_next      = open_reg;
        row_next       = row_reg;
        cell_next      = cell_reg;
        col_next       = col_reg;
        out_char_next  = out_char_reg;
        out_eol_next   = out_eol_reg;
        out_eof_next   = out_eof_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_wr) begin
            row_next  = '0;
            cell_next = '0;
            col_next  = '0;
        end else if (do_load) begin
            count_next = wr_en ? (load_base + CNT_W'(1)) : load_base;
            open_next  = !in_last_reg;
            row_next   = '0;
            cell_next  = '0;
            col_next   = '0;
        end else if (do_tick) begin
            out_valid_next = 1'b1;
            if (newline) begin
                out_char_next = ssr_pkg::CHAR_NEWLINE;
                out_eol_next  = 1'b1;
                out_eof_next  = (row_reg == last_row);
                cell_next     = '0;
                col_next      = '0;
                row_next      = (row_reg == last_row) ? '0 : (row_reg + ROW_W'(1));
            end else if (at_gap) begin
                out_char_next = ssr_pkg::CHAR_SPACE;
                out_eol_next  = 1'b0;
                out_eof_next  = 1'b0;
                cell_next     = cell_reg + ADDR_W'(1);
                col_next      = '0;
            end else begin
                out_char_next = glyph_char;
                out_eol_next  = 1'b0;
                out_eof_next  = 1'b0;
                col_next      = col_reg + COL_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scale_reg     <= ssr_pkg::SCALE_W'(2);
            count_reg     <= '0;
            open_reg      <= 1'b0;
            row_reg       <= '0;
            cell_reg      <= '0;
            col_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            scale_reg     <= scale_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            row_reg       <= row_next;
            cell_reg      <= cell_next;
            col_reg       <= col_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_kind_reg  <= s_tuser;
            in_digit_reg <= s_tdata[DW-1:0];
            in_last_reg  <= s_tlast;
        end
        out_char_reg <= out_char_next;
        out_eol_reg  <= out_eol_next;
        out_eof_reg  <= out_eof_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_eol_reg;
    assign m_tlast  = out_eof_reg;

    // The column never passes the gap after a cell.
    `SSR_ASSERT(a_col_in_range, aclk, aresetn, col_reg <= gap_col, "column beyond cell gap")
    // The digit count never exceeds the capacity.
    `SSR_ASSERT(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(MAX_DIGITS), "digit count beyond capacity")
    // A frame end is always also a line end carrying a newline.
    `SSR_ASSERT(a_eof_is_eol, aclk, aresetn, out_valid_reg && out_eof_reg |-> out_eol_reg && (out_char_reg == ssr_pkg::CHAR_NEWLINE), "frame end without newline")
    // A processed load leaves the raster at its origin.
    `SSR_ASSERT(a_load_restarts, aclk, aresetn, do_load |=> (row_reg == '0) && (cell_reg == '0) && (col_reg == '0), "load did not restart raster")

endmodule
